/* rtl/core/adf_pkg.sv */
`default_nettype none

package adf_pkg;

	// Register map: register i sits at byte address 8*i
	localparam int ADDR_W   = 6;
	localparam int DATA_W   = 64;
	localparam int REG_IDX_W = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_COEF_WORD_0     = 3'd0,
		REG_COEF_WORD_1     = 3'd1,
		REG_COEF_WORD_2     = 3'd2,
		REG_COEF_WORD_3     = 3'd3,
		REG_START_HISTORY_1 = 3'd4,
		REG_START_HISTORY_2 = 3'd5
	} reg_idx_t;

	// Frame and arithmetic constants
	localparam int FRAME_POS_W = 3;
	localparam int FRAC_BITS   = 11;
	localparam int HALF_Q11    = 'h400;
	localparam int SAMPLE_MIN  = -32768;
	localparam int SAMPLE_MAX  = 32767;
	localparam int ACC_W       = 34;

	// Sixteen Q11 coefficients, four per 64-bit word
	typedef logic [3:0][DATA_W-1:0] coef_bank_t;

	// Configuration seen by the decoder core
	typedef struct packed {
		coef_bank_t         coef_word;
		logic signed [15:0] start_history_one;
		logic signed [15:0] start_history_two;
	} cfg_t;

endpackage

`default_nettype wire

/* rtl/core/adf_apb_regs.sv */
`default_nettype none

module adf_apb_regs
	import adf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	coef_bank_t         coef_word_q;
	logic signed [15:0] start_h1_q;
	logic signed [15:0] start_h2_q;
	logic               wr_en;
	reg_idx_t           idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);

	// Write the addressed register; drop writes beyond the map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_word_q <= '0;
			start_h1_q  <= '0;
			start_h2_q  <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_COEF_WORD_0:     coef_word_q[0] <= pwdata;
				REG_COEF_WORD_1:     coef_word_q[1] <= pwdata;
				REG_COEF_WORD_2:     coef_word_q[2] <= pwdata;
				REG_COEF_WORD_3:     coef_word_q[3] <= pwdata;
				REG_START_HISTORY_1: start_h1_q     <= pwdata[15:0];
				REG_START_HISTORY_2: start_h2_q     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		case (idx)
			REG_COEF_WORD_0:     prdata = coef_word_q[0];
			REG_COEF_WORD_1:     prdata = coef_word_q[1];
			REG_COEF_WORD_2:     prdata = coef_word_q[2];
			REG_COEF_WORD_3:     prdata = coef_word_q[3];
			REG_START_HISTORY_1: prdata = {{(DATA_W-16){1'b0}}, start_h1_q};
			REG_START_HISTORY_2: prdata = {{(DATA_W-16){1'b0}}, start_h2_q};
			default:             prdata = '0;
		endcase
	end

	assign cfg.coef_word         = coef_word_q;
	assign cfg.start_history_one = start_h1_q;
	assign cfg.start_history_two = start_h2_q;

endmodule

`default_nettype wire

/* rtl/core/adf_sample_dp.sv */
`default_nettype none

module adf_sample_dp
	import adf_pkg::*;
(
	input  wire coef_bank_t    coef_word,
	input  wire logic [2:0]    coef_select,
	input  wire logic [3:0]    scale_shift,
	input  wire logic [3:0]    nibble,
	input  wire logic signed [15:0] history_one,
	input  wire logic signed [15:0] history_two,
	output logic signed [15:0] sample
);

	localparam logic signed [ACC_W-1:0] ACC_MIN  = ACC_W'(SAMPLE_MIN);
	localparam logic signed [ACC_W-1:0] ACC_MAX  = ACC_W'(SAMPLE_MAX);
	localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(HALF_Q11);

	logic [DATA_W-1:0]         word;
	logic [31:0]               pair;
	logic signed [15:0]        c1;
	logic signed [15:0]        c2;
	logic signed [31:0]        p1;
	logic signed [31:0]        p2;
	logic signed [ACC_W-1:0]   xn;
	logic signed [ACC_W-1:0]   acc;
	logic signed [ACC_W-1:0]   val;

	// Pick the coefficient pair: 2p on history one, 2p+1 on history two
	assign word = coef_word[coef_select[2:1]];
	assign pair = coef_select[0] ? word[63:32] : word[31:0];
	assign c1   = pair[15:0];
	assign c2   = pair[31:16];

	// Predict from history
	assign p1 = c1 * history_one;
	assign p2 = c2 * history_two;

	// Scale the sign-extended nibble into Q11
	assign xn = ({{(ACC_W-4){nibble[3]}}, nibble} <<< scale_shift) <<< FRAC_BITS;

	// Sum with rounding, floor to integer, clamp to 16 bits
	assign acc = xn + ACC_HALF + ACC_W'(p1) + ACC_W'(p2);
	assign val = acc >>> FRAC_BITS;

	always_comb begin
		if (val < ACC_MIN) begin
			sample = 16'sh8000;
		end else if (val > ACC_MAX) begin
			sample = 16'sh7FFF;
		end else begin
			sample = val[15:0];
		end
	end

endmodule

`default_nettype wire

/* rtl/core/adpcm_frame_decoder.sv */
`default_nettype none

// Channel    | Dir | Handshake              | Payload
// s_axis     | in  | tvalid / tready        | tdata[7:0] data_byte, tuser block_start/load
// m_axis     | out | tvalid / tready        | tdata[15:0] sample, tlast last_of_pair
// apb        | in  | psel / penable, pready | 64-bit registers at byte address 8*i
//
// A header byte only loads the frame state and gives no sample. A data byte
// gives one sample per nibble: each sample runs through the history multiply,
// accumulate and clamp combinationally, and the second sample needs the first
// as its history. The input register takes the next byte in the cycle the
// current one finishes. arst_n clears history, frame position and registers.
// A stall on m_axis holds the current sample; the input side stalls once its
// register is full.

module adpcm_frame_decoder
	import adf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,

	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [7:0]        s_axis_tdata,   // [7:0] data_byte
	input  wire logic [1:0]        s_axis_tuser,   // [0] block_start, [1] load_history

	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [15:0]            m_axis_tdata,   // [15:0] sample
	output logic                   m_axis_tlast,   // last_of_pair

	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready
);

	cfg_t                   cfg;

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   start_s1;
	logic                   load_s1;

	logic                   phase_q;
	logic [FRAME_POS_W-1:0] pos_q;
	logic [3:0]             scale_q;
	logic [2:0]             sel_q;
	logic signed [15:0]     h1_q;
	logic signed [15:0]     h2_q;

	logic                   out_valid_q;
	logic [15:0]            out_data_q;
	logic                   out_last_q;

	logic                   is_hdr;
	logic                   out_free;
	logic                   emit;
	logic                   consume;
	logic [3:0]             nibble;
	logic signed [15:0]     sample;
	logic                   accept;

	adf_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencing of the byte held in the input register
	assign is_hdr        = start_s1 || (pos_q == '0);
	assign out_free      = !out_valid_q || m_axis_tready;
	assign emit          = valid_s1 && !is_hdr && out_free;
	assign consume       = valid_s1 && (is_hdr || (out_free && phase_q));
	assign s_axis_tready = !valid_s1 || consume;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign nibble        = phase_q ? byte_s1[3:0] : byte_s1[7:4];

	adf_sample_dp u_dp (
		.coef_word   (cfg.coef_word),
		.coef_select (sel_q),
		.scale_shift (scale_q),
		.nibble      (nibble),
		.history_one (h1_q),
		.history_two (h2_q),
		.sample      (sample)
	);

	// Input register: hold the request until its work is done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1  <= s_axis_tdata;
			start_s1 <= s_axis_tuser[0];
			load_s1  <= s_axis_tuser[1];
		end
	end

	// Frame and filter state: header loads, samples advance history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			pos_q   <= '0;
			scale_q <= '0;
			sel_q   <= '0;
			h1_q    <= '0;
			h2_q    <= '0;
		end else if (valid_s1 && is_hdr) begin
			scale_q <= byte_s1[3:0];
			sel_q   <= byte_s1[6:4];
			pos_q   <= FRAME_POS_W'(1);
			phase_q <= 1'b0;
			if (start_s1 && load_s1) begin
				h1_q <= cfg.start_history_one;
				h2_q <= cfg.start_history_two;
			end
		end else if (emit) begin
			h2_q    <= h1_q;
			h1_q    <= sample;
			phase_q <= !phase_q;
			if (phase_q) begin
				pos_q <= pos_q + FRAME_POS_W'(1);
			end
		end
	end

	// Result register: advance on a free slot, hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= sample;
			out_last_q <= phase_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

/* tb/tb_adpcm_frame_decoder.sv */
`default_nettype none

module tb_adpcm_frame_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	import adf_pkg::*;

	// First register index past the map: writes there must be dropped
	localparam int FIRST_UNMAPPED = int'(REG_START_HISTORY_2) + 1;

	typedef enum {CFG_ZERO, CFG_ONES, CFG_EXTREME, CFG_FULL, CFG_MODERATE} cfg_style_t;

	typedef struct {
		logic signed [15:0] pcm;
		logic               last;
	} pcm_item_t;

	// Decoder model plus the queue of PCM samples still owed by the block
	class pcm_checker;
		coef_bank_t         coef_bank;
		logic signed [15:0] seed_one;
		logic signed [15:0] seed_two;
		logic signed [15:0] prev_one;
		logic signed [15:0] prev_two;
		logic [2:0]         frame_pos;
		logic [3:0]         shift;
		logic [2:0]         pair_sel;
		pcm_item_t          expected_pcm[$];
		int                 errors;

		function new();
			coef_bank = '0;
			seed_one  = '0;
			seed_two  = '0;
			prev_one  = '0;
			prev_two  = '0;
			frame_pos = '0;
			shift     = '0;
			pair_sel  = '0;
			errors    = 0;
		endfunction

		function void write_reg(int unsigned idx, logic [63:0] value);
			case (idx)
				REG_COEF_WORD_0, REG_COEF_WORD_1, REG_COEF_WORD_2, REG_COEF_WORD_3: begin
					coef_bank[idx[1:0]] = value;
				end
				REG_START_HISTORY_1: begin
					seed_one = value[15:0];
				end
				REG_START_HISTORY_2: begin
					seed_two = value[15:0];
				end
				default: begin
					// outside the map: drop the write
				end
			endcase
		endfunction

		function logic signed [15:0] coef_at(logic [3:0] k);
			return coef_bank[k[3:2]][{k[1:0], 4'b0} +: 16];
		endfunction

		// One nibble through the second-order filter, floor shift, clamp
		function logic signed [15:0] filter_nibble(logic [3:0] nib);
			longint xn;
			longint acc;
			longint val;
			xn  = nib[3] ? longint'(nib) - 16 : longint'(nib);
			xn  = xn * (longint'(1) << shift);
			acc = xn * 2048 + HALF_Q11
				+ longint'(coef_at({pair_sel, 1'b0})) * longint'(prev_one)
				+ longint'(coef_at({pair_sel, 1'b1})) * longint'(prev_two);
			val = acc >>> FRAC_BITS;
			if (val < SAMPLE_MIN)
				val = SAMPLE_MIN;
			if (val > SAMPLE_MAX)
				val = SAMPLE_MAX;
			prev_two = prev_one;
			prev_one = val[15:0];
			return val[15:0];
		endfunction

		// Note an accepted stream byte and queue the samples it yields
		function void take_byte(logic [7:0] b, logic start, logic load);
			pcm_item_t item;
			if (start || frame_pos == 3'd0) begin
				shift    = b[3:0];
				pair_sel = b[6:4];
				if (start && load) begin
					prev_one = seed_one;
					prev_two = seed_two;
				end
				frame_pos = 3'd1;
			end else begin
				item.pcm  = filter_nibble(b[7:4]);
				item.last = 1'b0;
				expected_pcm.push_back(item);
				item.pcm  = filter_nibble(b[3:0]);
				item.last = 1'b1;
				expected_pcm.push_back(item);
				frame_pos = frame_pos + 3'd1;
			end
		endfunction

		// Compare one accepted output sample with the oldest expectation
		function void check_pcm(logic [15:0] pcm, logic last);
			pcm_item_t want;
			if (expected_pcm.size() == 0) begin
				$display("%0t: unexpected sample: expected none, got pcm %0d last %b",
					$time, $signed(pcm), last);
				errors++;
				return;
			end
			want = expected_pcm.pop_front();
			if (pcm !== want.pcm) begin
				$display("%0t: pcm mismatch: expected %0d, got %0d",
					$time, want.pcm, $signed(pcm));
				errors++;
			end
			if (last !== want.last) begin
				$display("%0t: last_of_pair mismatch: expected %b, got %b",
					$time, want.last, last);
				errors++;
			end
		endfunction
	endclass

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	wire logic         s_axis_tready;
	logic [7:0]        s_axis_tdata  = '0;   // [7:0] data_byte
	logic [1:0]        s_axis_tuser  = '0;   // [0] block_start, [1] load_history
	wire logic         m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	wire logic [15:0]  m_axis_tdata;         // [15:0] sample
	wire logic         m_axis_tlast;         // last_of_pair
	logic              psel          = 1'b0;
	logic              penable       = 1'b0;
	logic              pwrite        = 1'b0;
	logic [ADDR_W-1:0] paddr         = '0;
	logic [DATA_W-1:0] pwdata        = '0;
	wire logic [DATA_W-1:0] prdata;
	wire logic         pready;

	int src_idle_pct  = 0;
	int sink_stall_pct = 0;

	pcm_checker sb = new();

	adpcm_frame_decoder u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #6 clk = ~clk;

	// Check accepted samples, then pick the next ready level
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_pcm(m_axis_tdata, m_axis_tlast);
		m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// Send one byte request; returns just after the accepting edge
	task automatic push_byte(input logic [7:0] b, input logic start, input logic load);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= {load, start};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.take_byte(b, start, load);
	endtask

	// Hold the sender until every sample has come, then let a header settle
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (sb.expected_pcm.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// Setup and access phase, then release the bus
	task automatic write_register(input int unsigned idx, input logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(idx << 3);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		sb.write_reg(idx, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [15:0] coef_lane(cfg_style_t st, int lane);
		case (st)
			CFG_ZERO:    return 16'h0000;
			CFG_ONES:    return 16'hFFFF;
			CFG_EXTREME: return lane[0] ? 16'h8000 : 16'h7FFF;
			CFG_FULL:    return 16'($urandom);
			default:     return 16'(int'($urandom_range(0, 8191)) - 4096);
		endcase
	endfunction

	// History seed with junk above bit 15
	function automatic logic [63:0] seed_word(cfg_style_t st, logic upper);
		logic [63:0] v;
		v = {$urandom, $urandom};
		case (st)
			CFG_ZERO:    v[15:0] = 16'h0000;
			CFG_ONES:    v[15:0] = 16'hFFFF;
			CFG_EXTREME: v[15:0] = upper ? 16'h8000 : 16'h7FFF;
			default:     v[15:0] = 16'($urandom);
		endcase
		return v;
	endfunction

	// Write every register, plus two addresses past the map
	task automatic apply_config(input cfg_style_t st);
		logic [63:0] w;
		for (int i = 0; i < 4; i++) begin
			for (int lane = 0; lane < 4; lane++)
				w[16*lane +: 16] = coef_lane(st, lane);
			write_register(int'(REG_COEF_WORD_0) + i, w);
		end
		write_register(REG_START_HISTORY_1, seed_word(st, 1'b0));
		write_register(REG_START_HISTORY_2, seed_word(st, 1'b1));
		write_register(FIRST_UNMAPPED, {$urandom, $urandom});
		write_register(FIRST_UNMAPPED + 1, {$urandom, $urandom});
	endtask

	// Mostly whole frames with random content, some stray and cut-short frames
	task automatic run_phase(input int n_bytes);
		int sent;
		int body;
		sent = 0;
		while (sent < n_bytes) begin
			if ($urandom_range(99) < 8) begin
				push_byte(8'($urandom), 1'($urandom), 1'($urandom));
				sent++;
			end else begin
				push_byte(8'($urandom), $urandom_range(3) == 0, 1'($urandom));
				body = ($urandom_range(99) < 6) ? $urandom_range(0, 6) : 7;
				for (int i = 0; i < body; i++)
					push_byte(8'($urandom), 1'b0, $urandom_range(9) == 0);
				sent += body + 1;
			end
		end
	endtask

	initial begin
		cfg_style_t styles[8];
		styles = '{CFG_ZERO, CFG_MODERATE, CFG_FULL, CFG_ONES,
			CFG_MODERATE, CFG_EXTREME, CFG_MODERATE, CFG_FULL};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: saturating coefficients, extreme seeds and nibbles
		apply_config(CFG_EXTREME);
		push_byte(8'h40, 1'b1, 1'b1);    // block start with history load
		push_byte(8'h00, 1'b0, 1'b0);
		push_byte(8'hFF, 1'b0, 1'b0);
		push_byte(8'h78, 1'b0, 1'b1);    // load without block start
		push_byte(8'h87, 1'b0, 1'b0);
		push_byte(8'h7F, 1'b0, 1'b0);
		push_byte(8'hF7, 1'b0, 1'b0);
		push_byte(8'h80, 1'b0, 1'b0);    // seventh data byte, frame wraps
		push_byte(8'h8F, 1'b0, 1'b1);    // header with no start, bit 7 set
		push_byte(8'h77, 1'b0, 1'b0);
		push_byte(8'h88, 1'b0, 1'b0);
		push_byte(8'h70, 1'b1, 1'b0);    // block start mid-frame
		push_byte(8'h01, 1'b0, 1'b0);
		push_byte(8'h10, 1'b0, 1'b0);
		push_byte(8'hFF, 1'b1, 1'b1);
		push_byte(8'h08, 1'b0, 1'b0);
		push_byte(8'h80, 1'b0, 1'b0);
		wait_idle();
		apply_config(CFG_ZERO);
		push_byte(8'h0F, 1'b1, 1'b1);
		push_byte(8'h87, 1'b0, 1'b0);
		push_byte(8'h78, 1'b0, 1'b0);

		// Random phases, rotating idle patterns and configurations
		for (int p = 0; p < 8; p++) begin
			wait_idle();
			apply_config(styles[p]);
			case (p % 4)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 47; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 47; end
				default: begin src_idle_pct = 6; sink_stall_pct = 6; end
			endcase
			run_phase(120);
			if (p == 2 || p == 5)
				wait_idle();
			run_phase(120);
		end

		wait_idle();
		if (sb.errors == 0)
			$display("adpcm_frame_decoder verification clean");
		else
			$display("adpcm_frame_decoder verification failed");
		$finish;
	end

	// Hard stop well past the slowest correct run
	initial begin
		#3_000_000;
		$display("adpcm_frame_decoder verification failed");
		$finish;
	end

endmodule

`default_nettype wire

/* adpcm_frame_decoder.f */
rtl/core/adf_pkg.sv
rtl/core/adf_apb_regs.sv
rtl/core/adf_sample_dp.sv
rtl/core/adpcm_frame_decoder.sv
tb/tb_adpcm_frame_decoder.sv
